// ===== hw/rtl/polar_angle_full_circle_unit_assert.svh =====
// Assertion macros for the RTL.
`ifndef POLAR_ANGLE_FULL_CIRCLE_UNIT_ASSERT_SVH
`define POLAR_ANGLE_FULL_CIRCLE_UNIT_ASSERT_SVH

// Checked out of reset only.
`define PAFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define PAFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/pafc_pkg.sv =====
package pafc_pkg;

  // CORDIC datapath is 64-bit two's complement, angles are Q30
  localparam int unsigned CORDIC_W   = 64;
  localparam int unsigned Q30_W      = 34;
  localparam int unsigned ATAN_IDX_W = 5;

  localparam logic [Q30_W-1:0] Q30_HALF_PI       = 34'd1686629713;
  localparam logic [Q30_W-1:0] Q30_PI            = 34'd3373259426;
  localparam logic [Q30_W-1:0] Q30_THREE_HALF_PI = 34'd5059889139;
  localparam logic [Q30_W-1:0] Q30_TWO_PI        = 34'd6746518852;

  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic signed [Q30_W-1:0]    zangle_t;

  // side information that travels alongside the CORDIC vector
  typedef struct packed {
    logic             undef;
    logic             axis;
    logic             x_neg;
    logic             y_neg;
    logic [Q30_W-1:0] axis_q30;
  } pafc_meta_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic [Q30_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [Q30_W-1:0] a;
    case (idx)
      5'd0:  a = 34'd843314857;
      5'd1:  a = 34'd497837829;
      5'd2:  a = 34'd263043837;
      5'd3:  a = 34'd133525159;
      5'd4:  a = 34'd67021687;
      5'd5:  a = 34'd33543516;
      5'd6:  a = 34'd16775851;
      5'd7:  a = 34'd8388437;
      5'd8:  a = 34'd4194283;
      5'd9:  a = 34'd2097149;
      5'd10: a = 34'd1048576;
      5'd11: a = 34'd524288;
      5'd12: a = 34'd262144;
      5'd13: a = 34'd131072;
      5'd14: a = 34'd65536;
      5'd15: a = 34'd32768;
      5'd16: a = 34'd16384;
      5'd17: a = 34'd8192;
      5'd18: a = 34'd4096;
      5'd19: a = 34'd2048;
      5'd20: a = 34'd1024;
      5'd21: a = 34'd512;
      5'd22: a = 34'd256;
      5'd23: a = 34'd128;
      5'd24: a = 34'd64;
      5'd25: a = 34'd32;
      5'd26: a = 34'd16;
      5'd27: a = 34'd8;
      5'd28: a = 34'd4;
      5'd29: a = 34'd2;
      5'd30: a = 34'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/pafc_cordic_stage.sv =====
module pafc_cordic_stage #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  pafc_pkg::cordic_t    x_i,
  input  pafc_pkg::cordic_t    y_i,
  input  pafc_pkg::zangle_t    z_i,
  input  pafc_pkg::pafc_meta_t meta_i,
  output pafc_pkg::cordic_t    x_o,
  output pafc_pkg::cordic_t    y_o,
  output pafc_pkg::zangle_t    z_o,
  output pafc_pkg::pafc_meta_t meta_o
);
  import pafc_pkg::*;

  cordic_t    x_sh, y_sh;
  zangle_t    step_ang;
  cordic_t    x_d, y_d, x_q, y_q;
  zangle_t    z_d, z_q;
  pafc_meta_t meta_q;

  // one micro-rotation, driving y towards zero
  always_comb begin
    x_sh     = x_i >>> STAGE_IDX;
    y_sh     = y_i >>> STAGE_IDX;
    step_ang = zangle_t'(atan_q30(ATAN_IDX_W'(STAGE_IDX)));
    if (!y_i[CORDIC_W-1]) begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + step_ang;
    end else begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - step_ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      meta_q <= meta_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign meta_o = meta_q;

endmodule

// ===== hw/rtl/polar_angle_full_circle_unit.sv =====
// Polar angle of a point over the full circle, [0, 2pi).
// Input stream: one beat per point, s_axis_tdata_i carries x_coord then y_coord,
// both signed, COORD_WIDTH bits each. Output stream: one beat per point, in order;
// m_axis_tdata_o carries the angle as unsigned radians with ANGLE_FRAC_BITS
// fraction bits, m_axis_tuser_o flags the origin (angle then 0).
// Points on an axis get exact constants; others go through a vectoring CORDIC
// of CORDIC_STAGES micro-rotations on the first-quadrant magnitudes.
// Stages: one prep stage, one register per micro-rotation, a quadrant combine
// stage, a rounding stage and the output register.
// Throughput: one beat per cycle while the skid is empty; every stage holds one 64-bit add or less.
// Stall: the output register is backed by a one-entry skid buffer. When the sink
// holds off, the next result parks in the skid and the pipeline then freezes with
// s_axis_tready_o low until the skid drains; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous): all valid bits clear, the pipeline is empty
// and s_axis_tready_o is high straight after.
`include "polar_angle_full_circle_unit_assert.svh"

module polar_angle_full_circle_unit #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned CORDIC_STAGES   = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // x_coord, y_coord, zero pad
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           s_axis_tdata_i,
  output logic                                         m_axis_tvalid_o,
  input  logic                                         m_axis_tready_i,
  // angle, zero pad
  output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]       m_axis_tdata_o,
  // undefined
  output logic                                         m_axis_tuser_o
);
  import pafc_pkg::*;

  localparam int unsigned ANGLE_W   = ANGLE_FRAC_BITS + 3;
  localparam int unsigned OUT_W     = ((ANGLE_W + 7) / 8) * 8;
  localparam int unsigned PRESHIFT  = 60 - COORD_WIDTH;
  localparam int unsigned NUM_STG   = CORDIC_STAGES + 3;
  localparam int unsigned CMB_STG   = CORDIC_STAGES + 1;
  localparam int unsigned RND_STG   = CORDIC_STAGES + 2;
  localparam int unsigned RND_SH    = 30 - ANGLE_FRAC_BITS;
  localparam logic [Q30_W:0] ROUND_HALF = (Q30_W + 1)'(1) << (RND_SH - 1);
  localparam logic [Q30_W:0] FULL_TURN  = ({1'b0, Q30_TWO_PI} + ROUND_HALF) >> RND_SH;

  // handshake and valid chain
  logic               adv;
  logic [NUM_STG-1:0] vld_q, vld_d;

  // prep stage
  logic [COORD_WIDTH-1:0] x_raw, y_raw, ax, ay;
  logic                   x_neg, y_neg, x_zero, y_zero;
  pafc_meta_t             meta0_d, meta0_q;
  cordic_t                x0_q, y0_q;

  cordic_t    x_arr    [0:CORDIC_STAGES];
  cordic_t    y_arr    [0:CORDIC_STAGES];
  zangle_t    z_arr    [0:CORDIC_STAGES];
  pafc_meta_t meta_arr [0:CORDIC_STAGES];

  // combine and rounding stages
  pafc_meta_t       mc;
  zangle_t          zc;
  logic [Q30_W-1:0] t_clamp, q30_d, q30_q;
  logic             cmb_undef_q;
  logic [Q30_W:0]   rnd_sum;
  logic [ANGLE_W-1:0] rnd_angle_d, rnd_angle_q;
  logic             rnd_undef_q;

  // output register and skid
  logic               out_free, arrive;
  logic               out_vld_q, skid_vld_q;
  logic [ANGLE_W-1:0] out_angle_q, skid_angle_q;
  logic               out_undef_q, skid_undef_q;

  assign adv             = ~skid_vld_q;
  assign s_axis_tready_o = adv;

  always_comb begin
    vld_d    = vld_q;
    if (adv) begin
      vld_d = {vld_q[NUM_STG-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---- prep: classify, fold to first quadrant, pre-scale
  assign x_raw  = s_axis_tdata_i[COORD_WIDTH-1:0];
  assign y_raw  = s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign x_neg  = x_raw[COORD_WIDTH-1];
  assign y_neg  = y_raw[COORD_WIDTH-1];
  assign x_zero = (x_raw == '0);
  assign y_zero = (y_raw == '0);
  assign ax     = x_neg ? (~x_raw + 1'b1) : x_raw;
  assign ay     = y_neg ? (~y_raw + 1'b1) : y_raw;

  always_comb begin
    meta0_d.undef    = x_zero & y_zero;
    meta0_d.axis     = x_zero | y_zero;
    meta0_d.x_neg    = x_neg;
    meta0_d.y_neg    = y_neg;
    meta0_d.axis_q30 = '0;
    if (x_zero && !y_zero) begin
      meta0_d.axis_q30 = y_neg ? Q30_THREE_HALF_PI : Q30_HALF_PI;
    end else if (y_zero && x_neg) begin
      meta0_d.axis_q30 = Q30_PI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid_i) begin
      x0_q    <= cordic_t'(ax) << PRESHIFT;
      y0_q    <= cordic_t'(ay) << PRESHIFT;
      meta0_q <= meta0_d;
    end
  end

  assign x_arr[0]    = x0_q;
  assign y_arr[0]    = y0_q;
  assign z_arr[0]    = '0;
  assign meta_arr[0] = meta0_q;

  // ---- CORDIC micro-rotations, one register stage each
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    pafc_cordic_stage #(
      .STAGE_IDX(i)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (adv & vld_q[i]),
      .x_i    (x_arr[i]),
      .y_i    (y_arr[i]),
      .z_i    (z_arr[i]),
      .meta_i (meta_arr[i]),
      .x_o    (x_arr[i+1]),
      .y_o    (y_arr[i+1]),
      .z_o    (z_arr[i+1]),
      .meta_o (meta_arr[i+1])
    );
  end

  // ---- combine: clamp to [0, pi/2] and apply the quadrant
  assign mc = meta_arr[CORDIC_STAGES];
  assign zc = z_arr[CORDIC_STAGES];

  always_comb begin
    if (zc[Q30_W-1]) begin
      t_clamp = '0;
    end else if ($unsigned(zc) > Q30_HALF_PI) begin
      t_clamp = Q30_HALF_PI;
    end else begin
      t_clamp = $unsigned(zc);
    end
    case ({mc.x_neg, mc.y_neg})
      2'b00:   q30_d = t_clamp;
      2'b01:   q30_d = Q30_TWO_PI - t_clamp;
      2'b10:   q30_d = Q30_PI - t_clamp;
      default: q30_d = Q30_PI + t_clamp;
    endcase
    if (mc.axis) begin
      q30_d = mc.axis_q30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[CMB_STG-1]) begin
      q30_q       <= q30_d;
      cmb_undef_q <= mc.undef;
    end
  end

  // ---- round to output precision, keep below a full turn
  always_comb begin
    rnd_sum = ({1'b0, q30_q} + ROUND_HALF) >> RND_SH;
    if (rnd_sum >= FULL_TURN) begin
      rnd_sum = FULL_TURN - 1'b1;
    end
    rnd_angle_d = rnd_sum[ANGLE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[RND_STG-1]) begin
      rnd_angle_q <= rnd_angle_d;
      rnd_undef_q <= cmb_undef_q;
    end
  end

  // ---- output register with one-entry skid
  assign out_free = ~out_vld_q | m_axis_tready_i;
  assign arrive   = adv & vld_q[RND_STG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_free) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (out_free) begin
        out_vld_q <= arrive;
      end else if (arrive) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_angle_q <= skid_angle_q;
        out_undef_q <= skid_undef_q;
      end
    end else if (out_free) begin
      if (arrive) begin
        out_angle_q <= rnd_angle_q;
        out_undef_q <= rnd_undef_q;
      end
    end else if (arrive) begin
      skid_angle_q <= rnd_angle_q;
      skid_undef_q <= rnd_undef_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'(out_angle_q);
  assign m_axis_tuser_o  = out_undef_q;

  // ---- assertions
  `PAFC_ASSERT(a_undef_zero_angle, m_axis_tvalid_o && m_axis_tuser_o |-> out_angle_q == '0,
               "origin beat with nonzero angle")
  `PAFC_ASSERT(a_angle_below_turn, m_axis_tvalid_o |-> (Q30_W + 1)'(out_angle_q) < FULL_TURN,
               "angle reached a full turn")
  `PAFC_ASSERT(a_stall_has_output, !s_axis_tready_o |-> m_axis_tvalid_o,
               "input stalled with no output pending")
  `PAFC_ASSERT(a_skid_fill_cause,
               $rose(skid_vld_q) |-> $past(m_axis_tvalid_o && !m_axis_tready_i),
               "skid filled without back-pressure")
  `PAFC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid_o && s_axis_tready_o,
                      "pipeline not empty in reset")

endmodule

// ===== tb/sv/polar_angle_checker.sv =====
module polar_angle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // x_coord, y_coord
  input  logic [31:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // angle
  input  logic [15:0] m_axis_tdata_i,
  // undefined
  input  logic        m_axis_tuser_i,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] angle;
    logic        origin;
  } angle_res_t;

  localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;
  localparam logic [63:0] PI_Q30            = 64'd3373259426;
  localparam logic [63:0] THREE_HALF_PI_Q30 = 64'd5059889139;
  localparam logic [63:0] TWO_PI_Q30        = 64'd6746518852;
  localparam logic [63:0] ROUND_HALF        = 64'd65536;      // half LSB of Q13 in Q30
  localparam logic [63:0] FULL_TURN_Q13     = (TWO_PI_Q30 + ROUND_HALF) >> 17;

  localparam logic [63:0] ATAN_Q30 [0:15] = '{
    64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
    64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
    64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
    64'd262144,    64'd131072,    64'd65536,     64'd32768
  };

  angle_res_t angle_due[$];
  int         errors = 0;

  function automatic angle_res_t polar_angle_q13(input logic [15:0] xr, input logic [15:0] yr);
    logic signed [63:0] cx, cy, cz, xs, ys;
    logic [63:0]        ax, ay, q30, t, rnd;
    angle_res_t         r;
    ax = xr[15] ? (64'd65536 - 64'(xr)) : 64'(xr);
    ay = yr[15] ? (64'd65536 - 64'(yr)) : 64'(yr);
    r.origin = 1'b0;
    if (xr == 16'd0 && yr == 16'd0) begin
      q30 = '0;
      r.origin = 1'b1;
    end else if (xr == 16'd0) begin
      q30 = yr[15] ? THREE_HALF_PI_Q30 : HALF_PI_Q30;
    end else if (yr == 16'd0) begin
      q30 = xr[15] ? PI_Q30 : 64'd0;
    end else begin
      // first-quadrant vectoring on magnitudes scaled up to bit 59
      cx = ax << 44;
      cy = ay << 44;
      cz = '0;
      for (int i = 0; i < 16; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (!cy[63]) begin
          cx = cx + ys;
          cy = cy - xs;
          cz = cz + ATAN_Q30[i];
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          cz = cz - ATAN_Q30[i];
        end
      end
      if (cz[63]) t = '0;
      else if (64'(cz) > HALF_PI_Q30) t = HALF_PI_Q30;
      else t = 64'(cz);
      if (!xr[15] && !yr[15]) q30 = t;
      else if (!xr[15]) q30 = TWO_PI_Q30 - t;
      else if (!yr[15]) q30 = PI_Q30 - t;
      else q30 = PI_Q30 + t;
    end
    rnd = (q30 + ROUND_HALF) >> 17;
    if (rnd >= FULL_TURN_Q13) rnd = FULL_TURN_Q13 - 64'd1;
    r.angle = rnd[15:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    angle_res_t due, got;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.angle  = m_axis_tdata_i;
        got.origin = m_axis_tuser_i;
        if (angle_due.size() == 0) begin
          if (errors < 10)
            $display("%t: result beat with none due: angle %0d undefined %0b",
                     $realtime, got.angle, got.origin);
          errors++;
        end else begin
          due = angle_due.pop_front();
          if (due.angle !== got.angle || due.origin !== got.origin) begin
            if (errors < 10)
              $display("%t: mismatch: angle exp %0d got %0d, undefined exp %0b got %0b",
                       $realtime, due.angle, got.angle, due.origin, got.origin);
            errors++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        angle_due.push_back(polar_angle_q13(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]));
    end
    pending_o <= angle_due.size();
    errors_o  <= errors;
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // x_coord, y_coord
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // angle
  logic        m_tuser;   // undefined
  int          pending;
  int          errors;
  logic        quiet;     // no idling on either side while set

  polar_angle_full_circle_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  polar_angle_checker angle_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // sink: short random stalls
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && !quiet && $urandom_range(99) < 5) hold = $urandom_range(3, 1);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_point(input logic [15:0] x, input logic [15:0] y);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 5) gap = $urandom_range(3, 1);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hffff;
      3: return 16'h0000;
      4: return 16'h0001;
      default: return 16'h7fff;
    endcase
  endfunction

  task automatic send_random_point();
    logic [15:0] x, y, m;
    int          kind;
    kind = $urandom_range(99);
    x = 16'($urandom);
    y = 16'($urandom);
    if (kind < 40) begin
      // full range, both fields random
    end else if (kind < 58) begin
      x = 16'($signed($urandom_range(128)) - 64);
      y = 16'($signed($urandom_range(128)) - 64);
    end else if (kind < 68) begin
      // on an axis
      if ($urandom_range(1)) x = '0;
      else y = '0;
    end else if (kind < 83) begin
      // just off an axis
      if ($urandom_range(1)) x = 16'($signed($urandom_range(6)) - 3);
      else y = 16'($signed($urandom_range(6)) - 3);
    end else if (kind < 90) begin
      m = 16'($urandom_range(32767, 1));
      x = $urandom_range(1) ? m : -m;
      y = $urandom_range(1) ? m : -m;
    end else if (kind < 98) begin
      x = pick_extreme();
      y = pick_extreme();
    end else begin
      x = '0;
      y = '0;
    end
    send_point(x, y);
  endtask

  initial begin
    int quiet_from;
    rst_ni   = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    quiet    = 1'b0;
    #1;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // axes, origin, corners, diagonals and the wrap just below a full turn
    send_point(16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h0000);
    send_point(16'h0000, 16'h7fff);
    send_point(16'h8000, 16'h0000);
    send_point(16'h0000, 16'h8000);
    send_point(16'h0001, 16'h0000);
    send_point(16'h0000, 16'h0001);
    send_point(16'hffff, 16'h0000);
    send_point(16'h0000, 16'hffff);
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000);
    send_point(16'h8000, 16'h7fff);
    send_point(16'h0001, 16'h0001);
    send_point(16'hffff, 16'hffff);
    send_point(16'h0001, 16'hffff);
    send_point(16'hffff, 16'h0001);
    send_point(16'h7fff, 16'hffff);
    send_point(16'h7fff, 16'h0001);
    send_point(16'h8000, 16'hffff);
    send_point(16'h8000, 16'h0001);
    send_point(16'h0001, 16'h7fff);
    send_point(16'hffff, 16'h8000);
    send_point(16'h5555, 16'haaaa);

    quiet_from = $urandom_range(500, 250);
    for (int n = 0; n < 1300; n++) begin
      quiet = (n >= quiet_from && n < quiet_from + 350);
      if (n == 700) begin
        // let the pipeline drain completely before carrying on
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      send_random_point();
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
